// ===== sv/texture_surface_size_core_assert.svh =====
// assertion macros for the surface size core
`ifndef TEXTURE_SURFACE_SIZE_CORE_ASSERT_SVH
`define TEXTURE_SURFACE_SIZE_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define TSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("surface size core check failed");

// condition implies consequence in the next cycle
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("surface size core check failed");

`endif

// ===== sv/tss_pkg.sv =====
// shared types, constants and format decode for the surface size core
`default_nettype none

package tss_pkg;

    localparam int DIM_BITS = 16;
    localparam int ROW_W    = 20;
    localparam int ROWS_W   = 17;
    localparam int TOTAL_W  = 36;
    localparam int PROD_W   = ROW_W + ROWS_W;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_BC,
        KIND_PACKED,
        KIND_NV11,
        KIND_PLANAR
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] bpe_sh;
    } class_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_bytes;
        logic [ROWS_W-1:0] row_count;
        logic [ROWS_W-1:0] mul_rows;
        logic              planar;
        logic              status;
    } entry_t;

    function automatic logic [7:0] bits_per_pixel(input logic [7:0] f);
        logic [7:0] bpp;
        unique case (f) inside
            [8'd1:8'd4]:                        bpp = 8'd128;
            [8'd5:8'd8]:                        bpp = 8'd96;
            [8'd9:8'd22], 8'd102, 8'd108, 8'd109: bpp = 8'd64;
            [8'd23:8'd47], [8'd67:8'd69], [8'd87:8'd93], 8'd100, 8'd101, 8'd107:
                                                bpp = 8'd32;
            [8'd48:8'd59], 8'd85, 8'd86, 8'd114, 8'd115, 8'd130, 8'd131:
                                                bpp = 8'd16;
            [8'd60:8'd65], [8'd73:8'd78], [8'd82:8'd84], [8'd94:8'd99], [8'd111:8'd113]:
                                                bpp = 8'd8;
            8'd66:                              bpp = 8'd1;
            [8'd70:8'd72], [8'd79:8'd81]:       bpp = 8'd4;
            8'd103, 8'd106, 8'd110:             bpp = 8'd12;
            8'd104, 8'd105, 8'd132:             bpp = 8'd24;
            default:                            bpp = 8'd0;
        endcase
        return bpp;
    endfunction

    function automatic class_t classify(input logic [7:0] f);
        class_t c;
        unique case (f) inside
            [8'd70:8'd72], [8'd79:8'd81]:               c = '{KIND_BC, 3'd3};
            [8'd73:8'd78], [8'd82:8'd84], [8'd94:8'd99]: c = '{KIND_BC, 3'd4};
            8'd68, 8'd69, 8'd107:                       c = '{KIND_PACKED, 3'd2};
            8'd108, 8'd109:                             c = '{KIND_PACKED, 3'd3};
            8'd110:                                     c = '{KIND_NV11, 3'd2};
            8'd103, 8'd106, 8'd130:                     c = '{KIND_PLANAR, 3'd1};
            8'd104, 8'd105:                             c = '{KIND_PLANAR, 3'd2};
            default:                                    c = '{KIND_PLAIN, 3'd0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tss_front.sv =====
// front end: decodes the format and works out row pitch and row counts
`default_nettype none

module tss_front
    import tss_pkg::*;
(
    input  wire logic [7:0]  format_code,
    input  wire logic [15:0] width,
    input  wire logic [15:0] height,
    output entry_t           entry
);

    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    class_t              cls;
    logic [7:0]          bpp;
    logic [DIM_BITS:0]   w_quad;
    logic [DIM_BITS:0]   w_pair;
    logic [DIM_BITS:0]   h_quad;
    logic [DIM_BITS:0]   h_half;
    logic [DIM_BITS+8:0] bits_row;
    logic [ROW_W-1:0]    blocks_w;
    logic [ROW_W-1:0]    pairs_w;

    always_comb
    begin
        w        = width[DIM_BITS-1:0];
        h        = height[DIM_BITS-1:0];
        cls      = classify(format_code);
        bpp      = bits_per_pixel(format_code);
        w_quad   = ({1'b0, w} + (DIM_BITS+1)'(3)) >> 2;
        w_pair   = ({1'b0, w} + (DIM_BITS+1)'(1)) >> 1;
        h_quad   = ({1'b0, h} + (DIM_BITS+1)'(3)) >> 2;
        h_half   = ({1'b0, h} + (DIM_BITS+1)'(1)) >> 1;
        bits_row = (DIM_BITS+9)'(w) * (DIM_BITS+9)'(bpp) + (DIM_BITS+9)'(7);
        blocks_w = ROW_W'(w_quad);
        pairs_w  = ROW_W'(w_pair);

        entry.planar = 1'b0;
        entry.status = 1'b0;
        unique case (cls.kind)
            KIND_BC:
            begin
                entry.row_bytes = blocks_w << cls.bpe_sh;
                entry.row_count = ROWS_W'(h_quad);
                entry.mul_rows  = ROWS_W'(h_quad);
            end
            KIND_PACKED:
            begin
                entry.row_bytes = pairs_w << cls.bpe_sh;
                entry.row_count = ROWS_W'(h);
                entry.mul_rows  = ROWS_W'(h);
            end
            KIND_NV11:
            begin
                entry.row_bytes = blocks_w << cls.bpe_sh;
                entry.row_count = ROWS_W'({h, 1'b0});
                entry.mul_rows  = ROWS_W'({h, 1'b0});
            end
            KIND_PLANAR:
            begin
                entry.row_bytes = pairs_w << cls.bpe_sh;
                entry.row_count = ROWS_W'((DIM_BITS+1)'(h) + h_half);
                entry.mul_rows  = ROWS_W'(h);
                entry.planar    = 1'b1;
            end
            default:
            begin
                if (bpp == 8'd0)
                begin
                    entry.row_bytes = '0;
                    entry.row_count = '0;
                    entry.mul_rows  = '0;
                    entry.status    = 1'b1;
                end
                else
                begin
                    entry.row_bytes = ROW_W'(bits_row >> 3);
                    entry.row_count = ROWS_W'(h);
                    entry.mul_rows  = ROWS_W'(h);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tss_queue.sv =====
// short item queue between the front and back ends
`default_nettype none

module tss_queue
    import tss_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire entry_t push_data,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output entry_t      pop_data
);

    entry_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;
    logic            push;
    logic            pop;

    always_comb
    begin
        push_ready  = count_reg != (Q_AW+1)'(Q_DEPTH);
        pop_valid   = count_reg != '0;
        pop_data    = slot_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tss_back.sv =====
// back end: multiplies out the total size and holds the result item
`default_nettype none

module tss_back
    import tss_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop_ready,
    input  wire entry_t       pop_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [ROW_W-1:0]  row_bytes,
    output logic [ROWS_W-1:0] row_count,
    output logic [TOTAL_W-1:0] total_bytes,
    output logic              status
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [ROWS_W-1:0]  s1_rows_reg;
    logic               s1_planar_reg;
    logic               s1_status_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               status_reg;
    logic               load1;
    logic               load2;

    always_comb
    begin
        load2          = s1_valid_reg && (!out_valid_reg || out_ready);
        pop_ready      = !s1_valid_reg || load2;
        load1          = pop_valid && pop_ready;
        s1_valid_next  = load1 ? 1'b1 : (load2 ? 1'b0 : s1_valid_reg);
        out_valid_next = load2 ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        if (s1_planar_reg)
        begin
            total_next = TOTAL_W'((PROD_W+1)'(prod_reg)
                       + (((PROD_W+1)'(prod_reg) + (PROD_W+1)'(1)) >> 1));
        end
        else
        begin
            total_next = TOTAL_W'(prod_reg);
        end
        out_valid   = out_valid_reg;
        row_bytes   = row_reg;
        row_count   = rows_reg;
        total_bytes = total_reg;
        status      = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            prod_reg      <= PROD_W'(pop_data.row_bytes) * PROD_W'(pop_data.mul_rows);
            s1_row_reg    <= pop_data.row_bytes;
            s1_rows_reg   <= pop_data.row_count;
            s1_planar_reg <= pop_data.planar;
            s1_status_reg <= pop_data.status;
        end
        if (load2)
        begin
            row_reg    <= s1_row_reg;
            rows_reg   <= s1_rows_reg;
            total_reg  <= total_next;
            status_reg <= s1_status_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/texture_surface_size_core.sv =====
// top level of the surface size core
//
// input channel in_valid/in_ready carries one query item: format_code, width,
// height. output channel out_valid/out_ready carries one result item per
// query: row_bytes, row_count, total_bytes and status (1 for unknown format,
// all sizes then zero).
// one item per cycle sustained while out_ready stays high; an accepted
// item passes the queue slot, the back end first stage and the output
// register to out_valid: the front end decode feeds a 4-entry queue in
// the accept cycle, the back end multiplies row pitch by rows in its first
// stage and adds planar chroma into the output register in its second.
// when out_ready is low the result holds, the back end fills, then the queue
// fills; in_ready falls only once all 4 queue entries are taken.
// reset empties the queue and both back end stages; in_ready is high right
// after reset.
`default_nettype none

`include "texture_surface_size_core_assert.svh"

module texture_surface_size_core
    import tss_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    format_code,
    input  wire logic [15:0]   width,
    input  wire logic [15:0]   height,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [19:0]        row_bytes,
    output logic [16:0]        row_count,
    output logic [35:0]        total_bytes,
    output logic               status
);

    entry_t front_entry;
    entry_t q_data;
    logic   q_valid;
    logic   q_ready;

    tss_front u_front (
        .format_code (format_code),
        .width       (width),
        .height      (height),
        .entry       (front_entry)
    );

    tss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    tss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (q_valid),
        .pop_ready   (q_ready),
        .pop_data    (q_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_bytes   (row_bytes),
        .row_count   (row_count),
        .total_bytes (total_bytes),
        .status      (status)
    );

    `TSS_ASSERT_NOW(a_invalid_zero, out_valid && status,
        row_bytes == '0 && row_count == '0 && total_bytes == '0)
    `TSS_ASSERT_NOW(a_full_not_empty, !in_ready, q_valid)
    `TSS_ASSERT_NEXT(a_push_lands, in_valid && in_ready, q_valid)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for texture_surface_size_core: surface size queries checked against a predictor
`default_nettype none

module tb
    import tss_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FMT_UNKNOWN                = 8'd0;
    localparam logic [7:0] FMT_R32G32B32A32_TYPELESS  = 8'd1;
    localparam logic [7:0] FMT_R32G32B32A32_SINT      = 8'd4;
    localparam logic [7:0] FMT_R32G32B32_TYPELESS     = 8'd5;
    localparam logic [7:0] FMT_R32G32B32_SINT         = 8'd8;
    localparam logic [7:0] FMT_R16G16B16A16_TYPELESS  = 8'd9;
    localparam logic [7:0] FMT_X32_G8X24_UINT         = 8'd22;
    localparam logic [7:0] FMT_R10G10B10A2_TYPELESS   = 8'd23;
    localparam logic [7:0] FMT_X24_G8_UINT            = 8'd47;
    localparam logic [7:0] FMT_R8G8_TYPELESS          = 8'd48;
    localparam logic [7:0] FMT_R16_SINT               = 8'd59;
    localparam logic [7:0] FMT_R8_TYPELESS            = 8'd60;
    localparam logic [7:0] FMT_A8_UNORM               = 8'd65;
    localparam logic [7:0] FMT_R1_UNORM               = 8'd66;
    localparam logic [7:0] FMT_R9G9B9E5_SHAREDEXP     = 8'd67;
    localparam logic [7:0] FMT_R8G8_B8G8_UNORM        = 8'd68;
    localparam logic [7:0] FMT_G8R8_G8B8_UNORM        = 8'd69;
    localparam logic [7:0] FMT_BC1_TYPELESS           = 8'd70;
    localparam logic [7:0] FMT_BC1_UNORM_SRGB         = 8'd72;
    localparam logic [7:0] FMT_BC2_TYPELESS           = 8'd73;
    localparam logic [7:0] FMT_BC3_UNORM_SRGB         = 8'd78;
    localparam logic [7:0] FMT_BC4_TYPELESS           = 8'd79;
    localparam logic [7:0] FMT_BC4_SNORM              = 8'd81;
    localparam logic [7:0] FMT_BC5_TYPELESS           = 8'd82;
    localparam logic [7:0] FMT_BC5_SNORM              = 8'd84;
    localparam logic [7:0] FMT_B5G6R5_UNORM           = 8'd85;
    localparam logic [7:0] FMT_B5G5R5A1_UNORM         = 8'd86;
    localparam logic [7:0] FMT_B8G8R8A8_UNORM         = 8'd87;
    localparam logic [7:0] FMT_B8G8R8X8_UNORM_SRGB    = 8'd93;
    localparam logic [7:0] FMT_BC6H_TYPELESS          = 8'd94;
    localparam logic [7:0] FMT_BC7_UNORM_SRGB         = 8'd99;
    localparam logic [7:0] FMT_AYUV                   = 8'd100;
    localparam logic [7:0] FMT_Y410                   = 8'd101;
    localparam logic [7:0] FMT_Y416                   = 8'd102;
    localparam logic [7:0] FMT_NV12                   = 8'd103;
    localparam logic [7:0] FMT_P010                   = 8'd104;
    localparam logic [7:0] FMT_P016                   = 8'd105;
    localparam logic [7:0] FMT_420_OPAQUE             = 8'd106;
    localparam logic [7:0] FMT_YUY2                   = 8'd107;
    localparam logic [7:0] FMT_Y210                   = 8'd108;
    localparam logic [7:0] FMT_Y216                   = 8'd109;
    localparam logic [7:0] FMT_NV11                   = 8'd110;
    localparam logic [7:0] FMT_AI44                   = 8'd111;
    localparam logic [7:0] FMT_P8                     = 8'd113;
    localparam logic [7:0] FMT_A8P8                   = 8'd114;
    localparam logic [7:0] FMT_B4G4R4A4_UNORM         = 8'd115;
    localparam logic [7:0] FMT_GAP_FIRST              = 8'd116;
    localparam logic [7:0] FMT_GAP_LAST               = 8'd129;
    localparam logic [7:0] FMT_P208                   = 8'd130;
    localparam logic [7:0] FMT_V208                   = 8'd131;
    localparam logic [7:0] FMT_V408                   = 8'd132;
    localparam logic [7:0] FMT_TOP_FIRST              = 8'd133;
    localparam logic [7:0] FMT_CODE_MAX               = 8'd255;

    localparam logic [15:0] DIM_MAX     = 16'hFFFF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        logic [19:0] row_bytes;
        logic [16:0] row_count;
        logic [35:0] total_bytes;
        logic        status;
    } surface_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  format_code = '0;
    logic [15:0] width = '0;
    logic [15:0] height = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [19:0] row_bytes;
    logic [16:0] row_count;
    logic [35:0] total_bytes;
    logic        status;

    surface_t    pending_sizes[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    texture_surface_size_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .format_code (format_code),
        .width       (width),
        .height      (height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_bytes   (row_bytes),
        .row_count   (row_count),
        .total_bytes (total_bytes),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic kind_t format_layout(input logic [7:0] f, output longint unsigned bpe);
        bpe = 0;
        if (f inside {[FMT_BC1_TYPELESS:FMT_BC1_UNORM_SRGB], [FMT_BC4_TYPELESS:FMT_BC4_SNORM]})
        begin
            bpe = 8;
            return KIND_BC;
        end
        if (f inside {[FMT_BC2_TYPELESS:FMT_BC3_UNORM_SRGB], [FMT_BC5_TYPELESS:FMT_BC5_SNORM],
                      [FMT_BC6H_TYPELESS:FMT_BC7_UNORM_SRGB]})
        begin
            bpe = 16;
            return KIND_BC;
        end
        if (f inside {FMT_R8G8_B8G8_UNORM, FMT_G8R8_G8B8_UNORM, FMT_YUY2})
        begin
            bpe = 4;
            return KIND_PACKED;
        end
        if (f inside {FMT_Y210, FMT_Y216})
        begin
            bpe = 8;
            return KIND_PACKED;
        end
        if (f == FMT_NV11)
            return KIND_NV11;
        if (f inside {FMT_NV12, FMT_420_OPAQUE, FMT_P208})
        begin
            bpe = 2;
            return KIND_PLANAR;
        end
        if (f inside {FMT_P010, FMT_P016})
        begin
            bpe = 4;
            return KIND_PLANAR;
        end
        return KIND_PLAIN;
    endfunction

    // bits per pixel of the plain formats, zero when the code is unknown
    function automatic longint unsigned format_bpp(input logic [7:0] f);
        if (f inside {[FMT_R32G32B32A32_TYPELESS:FMT_R32G32B32A32_SINT]})
            return 128;
        if (f inside {[FMT_R32G32B32_TYPELESS:FMT_R32G32B32_SINT]})
            return 96;
        if (f inside {[FMT_R16G16B16A16_TYPELESS:FMT_X32_G8X24_UINT], FMT_Y416})
            return 64;
        if (f inside {[FMT_R10G10B10A2_TYPELESS:FMT_X24_G8_UINT], FMT_R9G9B9E5_SHAREDEXP,
                      [FMT_B8G8R8A8_UNORM:FMT_B8G8R8X8_UNORM_SRGB], FMT_AYUV, FMT_Y410})
            return 32;
        if (f inside {[FMT_R8G8_TYPELESS:FMT_R16_SINT], FMT_B5G6R5_UNORM, FMT_B5G5R5A1_UNORM,
                      FMT_A8P8, FMT_B4G4R4A4_UNORM, FMT_V208})
            return 16;
        if (f inside {[FMT_R8_TYPELESS:FMT_A8_UNORM], [FMT_AI44:FMT_P8]})
            return 8;
        if (f == FMT_R1_UNORM)
            return 1;
        if (f == FMT_V408)
            return 24;
        return 0;
    endfunction

    function automatic surface_t predict_surface(input logic [7:0] fmt,
                                                 input logic [15:0] w_in,
                                                 input logic [15:0] h_in);
        surface_t          s;
        kind_t             layout;
        longint unsigned   w, h, bpe, bpp, row, rows, total, luma;
        w = 64'(w_in);
        h = 64'(h_in);
        row = 0;
        rows = 0;
        total = 0;
        s.status = 1'b0;
        layout = format_layout(fmt, bpe);
        case (layout)
            KIND_BC:
            begin
                row = ((w + 3) / 4) * bpe;
                rows = (h + 3) / 4;
                total = row * rows;
            end
            KIND_PACKED:
            begin
                row = ((w + 1) >> 1) * bpe;
                rows = h;
                total = row * h;
            end
            KIND_NV11:
            begin
                row = ((w + 3) >> 2) * 4;
                rows = h * 2;
                total = row * rows;
            end
            KIND_PLANAR:
            begin
                row = ((w + 1) >> 1) * bpe;
                luma = row * h;
                total = luma + ((luma + 1) >> 1);
                rows = h + ((h + 1) >> 1);
            end
            default:
            begin
                bpp = format_bpp(fmt);
                if (bpp == 0)
                    s.status = 1'b1;
                else
                begin
                    row = (w * bpp + 7) / 8;
                    rows = h;
                    total = row * h;
                end
            end
        endcase
        s.row_bytes = row[19:0];
        s.row_count = rows[16:0];
        s.total_bytes = total[35:0];
        return s;
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 9));
            1: return 16'($urandom_range(0, 1023));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'd0;
                    1: return 16'd1;
                    2: return DIM_MAX - 16'd1;
                    default: return DIM_MAX;
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_format();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 2))
                0: return FMT_UNKNOWN;
                1: return 8'($urandom_range(FMT_GAP_FIRST, FMT_GAP_LAST));
                default: return 8'($urandom_range(FMT_TOP_FIRST, FMT_CODE_MAX));
            endcase
        end
        if (r < 16)
            return 8'($urandom_range(FMT_P208, FMT_V408));
        return 8'($urandom_range(FMT_R32G32B32A32_TYPELESS, FMT_B4G4R4A4_UNORM));
    endfunction

    // presents one query item and returns in the step it is accepted
    task automatic send_query(input logic [7:0] fmt, input logic [15:0] w, input logic [15:0] h);
        if (!tx_steady && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        format_code <= fmt;
        width <= w;
        height <= h;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pending_sizes.push_back(predict_surface(fmt, w, h));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_sizes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_format_extremes();
        send_query(FMT_UNKNOWN, DIM_MAX, DIM_MAX);
        send_query(FMT_GAP_FIRST, 16'd7, 16'd9);
        send_query(FMT_GAP_LAST, 16'd1, 16'd1);
        send_query(FMT_TOP_FIRST, 16'd100, 16'd0);
        send_query(FMT_CODE_MAX, DIM_MAX, DIM_MAX);
        send_query(FMT_R32G32B32A32_TYPELESS, DIM_MAX, DIM_MAX);
        send_query(FMT_R32G32B32_SINT, DIM_MAX, 16'd1);
        send_query(FMT_R1_UNORM, 16'd1, 16'd1);
        send_query(FMT_R1_UNORM, DIM_MAX, 16'd3);
        send_query(FMT_R8_TYPELESS, 16'd0, 16'd0);
        send_query(FMT_A8_UNORM, 16'd7, 16'd0);
        send_query(FMT_BC1_TYPELESS, 16'd0, 16'd5);
        send_query(FMT_BC1_UNORM_SRGB, 16'd1, 16'd1);
        send_query(FMT_BC5_SNORM, 16'd5, 16'd0);
        send_query(FMT_BC7_UNORM_SRGB, DIM_MAX, DIM_MAX);
        send_query(FMT_YUY2, 16'd1, 16'd3);
        send_query(FMT_Y216, DIM_MAX, DIM_MAX);
        send_query(FMT_NV11, 16'd1, 16'd1);
        send_query(FMT_NV11, DIM_MAX, DIM_MAX);
        send_query(FMT_NV12, 16'd3, 16'd3);
        send_query(FMT_P016, DIM_MAX, DIM_MAX);
        send_query(FMT_P208, 16'd1, 16'd1);
        send_query(FMT_V408, 16'd3, 16'd2);
        send_query(FMT_B4G4R4A4_UNORM, 16'd5, 16'd5);
    endtask

    task automatic test_random_queries(input int unsigned count);
        repeat (count)
            send_query(pick_format(), pick_dim(), pick_dim());
    endtask

    // sender holds off until every outstanding result is back, then resumes
    task automatic test_paused_drain();
        test_random_queries(12);
        wait_drained();
        repeat ($urandom_range(2, 10)) @(posedge clk);
        test_random_queries(12);
    endtask

    // saturated sender, first with a free receiver and then with stalls
    task automatic test_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_queries(30);
        rx_steady = 1'b0;
        test_random_queries(30);
        tx_steady = 1'b0;
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin : rx_pattern
        int unsigned run_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            run_left = 0;
        end
        else if (rx_steady)
            out_ready <= 1'b1;
        else if (run_left == 0)
        begin
            out_ready <= !out_ready;
            run_left = out_ready ? $urandom_range(0, 9) : $urandom_range(0, 15);
        end
        else
            run_left--;
    end

    always @(posedge clk)
    begin : check_results
        surface_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_sizes.size() == 0)
            begin
                $error("result item with no query outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_sizes.pop_front();
                if (row_bytes !== want.row_bytes)
                begin
                    $error("row_bytes expected %0d got %0d", want.row_bytes, row_bytes);
                    mismatch_count++;
                end
                if (row_count !== want.row_count)
                begin
                    $error("row_count expected %0d got %0d", want.row_count, row_count);
                    mismatch_count++;
                end
                if (total_bytes !== want.total_bytes)
                begin
                    $error("total_bytes expected %0d got %0d", want.total_bytes, total_bytes);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_format_extremes();
        test_random_queries(150);
        test_paused_drain();
        test_back_to_back();
        test_random_queries(150);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_sizes.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
